// File: rtl/pntp_pkg.sv
// Shared types and constants for the PWM nanosecond-to-prescale block.
package pntp_pkg;

    localparam int PCLK_W  = 28;
    localparam int TICK_W  = 30;
    localparam int NS_W    = 32;
    localparam int COUNT_W = 16;
    localparam int CODE_W  = 4;
    localparam int CH_W    = 3;
    localparam int MODE_W  = 2;

    localparam logic [NS_W-1:0]    NS_PER_S    = 32'd1000000000;
    localparam logic [NS_W-1:0]    COUNT_LIMIT = 32'h0000_FFFF;
    localparam logic [PCLK_W-1:0]  PCLK_RESET  = 28'd100000000;

    localparam logic [MODE_W-1:0] MODE_SET     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ENABLE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DISABLE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_PDIV,
        ST_TICK0,
        ST_CNT0,
        ST_SEARCH,
        ST_TICKK,
        ST_PDIV2,
        ST_WDIV,
        ST_MUL_P,
        ST_MUL_W,
        ST_DONE
    } state_t;

endpackage

// File: rtl/pntp_div.sv
// Bit-serial restoring divider: 32-bit dividend by 30-bit divisor, one quotient bit a cycle.
module pntp_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pntp_pkg::NS_W-1:0]    dividend,
    input  logic [pntp_pkg::TICK_W-1:0]  divisor,
    output logic                         done,
    output logic [pntp_pkg::NS_W-1:0]    quotient
);

    localparam int STEP_W = $clog2(pntp_pkg::NS_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(pntp_pkg::NS_W - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             cnt_reg, cnt_next;
    logic [pntp_pkg::TICK_W-1:0]   rem_reg, rem_next;
    logic [pntp_pkg::TICK_W-1:0]   dvsr_reg, dvsr_next;
    logic [pntp_pkg::NS_W-1:0]     quo_reg, quo_next;
    logic [pntp_pkg::TICK_W:0]     trial;
    logic [pntp_pkg::TICK_W:0]     diff;
    logic                          fits;

    always_comb begin
        trial = {rem_reg, quo_reg[pntp_pkg::NS_W-1]};
        diff  = trial - {1'b0, dvsr_reg};
        fits  = trial >= {1'b0, dvsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvsr_next = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            rem_next = fits ? diff[pntp_pkg::TICK_W-1:0] : trial[pntp_pkg::TICK_W-1:0];
            quo_next = {quo_reg[pntp_pkg::NS_W-2:0], fits};
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/pntp_mul.sv
// Bit-serial shift-add multiplier: tick times 16-bit count, wrapped to 32 bits.
module pntp_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pntp_pkg::TICK_W-1:0]   mcand,
    input  logic [pntp_pkg::COUNT_W-1:0]  mplier,
    output logic                          done,
    output logic [pntp_pkg::NS_W-1:0]     product
);

    localparam int STEP_W = $clog2(pntp_pkg::COUNT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(pntp_pkg::COUNT_W - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             cnt_reg, cnt_next;
    logic [pntp_pkg::NS_W-1:0]     acc_reg, acc_next;
    logic [pntp_pkg::NS_W-1:0]     mcand_reg, mcand_next;
    logic [pntp_pkg::COUNT_W-1:0]  mplier_reg, mplier_next;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = {{(pntp_pkg::NS_W - pntp_pkg::TICK_W){1'b0}}, mcand};
            mplier_next = mplier;
        end else if (busy_reg) begin
            cnt_next    = cnt_reg + 1'b1;
            acc_next    = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
            mcand_next  = {mcand_reg[pntp_pkg::NS_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[pntp_pkg::COUNT_W-1:1]};
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: rtl/pwm_ns_to_timer_prescale.sv
// Top level: PWM timer front end converting nanosecond requests to prescale and counts.
//
// One request at a time; the result sits in an output register so the next request
// can be taken while it waits. Each request is worked out on the shared bit-serial
// divider and multiplier: enable and disable go straight to the result, get takes
// one division and two products, set takes three divisions when the current prescale
// fits, and up to seven divisions plus one halving step per code tried when a new
// prescale is searched.
module pwm_ns_to_timer_prescale #(
    parameter int NUM_CHANNELS = 8,
    parameter int MAX_DIV_CODE = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [pntp_pkg::PCLK_W-1:0]     cfg_wr_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pntp_pkg::MODE_W-1:0]     s_mode,
    input  logic [pntp_pkg::CH_W-1:0]       s_channel,
    input  logic [pntp_pkg::NS_W-1:0]       s_period_ns,
    input  logic [pntp_pkg::NS_W-1:0]       s_pulse_ns,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_status,
    output logic [pntp_pkg::NS_W-1:0]       m_period_ns_out,
    output logic [pntp_pkg::NS_W-1:0]       m_pulse_ns_out
);

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [pntp_pkg::CH_W:0]     NCH      = (pntp_pkg::CH_W + 1)'(NUM_CHANNELS);
    localparam logic [pntp_pkg::CODE_W-1:0] MAX_CODE = pntp_pkg::CODE_W'(MAX_DIV_CODE);

    pntp_pkg::state_t state_reg, state_next;
    logic launch_reg, launch_next;

    logic [pntp_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [pntp_pkg::CH_W-1:0]     ch_reg, ch_next;
    logic [pntp_pkg::NS_W-1:0]     period_reg, period_next;
    logic [pntp_pkg::NS_W-1:0]     pulse_reg, pulse_next;
    logic [pntp_pkg::TICK_W-1:0]   tick_reg, tick_next;
    logic [pntp_pkg::COUNT_W-1:0]  pcount_reg, pcount_next;
    logic [pntp_pkg::NS_W-1:0]     cnt_reg, cnt_next;
    logic [pntp_pkg::CODE_W-1:0]   k_reg, k_next;
    logic [pntp_pkg::CODE_W-1:0]   code_new_reg, code_new_next;
    logic                          status_reg, status_next;
    logic [pntp_pkg::NS_W-1:0]     pout_reg, pout_next;
    logic [pntp_pkg::NS_W-1:0]     wout_reg, wout_next;

    logic                          m_valid_reg, m_valid_next;
    logic                          m_status_reg, m_status_next;
    logic [pntp_pkg::NS_W-1:0]     m_pout_reg, m_pout_next;
    logic [pntp_pkg::NS_W-1:0]     m_wout_reg, m_wout_next;

    logic [pntp_pkg::PCLK_W-1:0]   pclk_reg, pclk_next;
    logic [pntp_pkg::CODE_W-1:0]   div_code_reg, div_code_next;
    logic [pntp_pkg::COUNT_W-1:0]  period_count_reg, period_count_next;
    logic [pntp_pkg::COUNT_W-1:0]  compare_reg [NUM_CHANNELS];
    logic [pntp_pkg::COUNT_W-1:0]  compare_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]       enable_reg, enable_next;

    logic                          div_start, div_done;
    logic [pntp_pkg::NS_W-1:0]     div_dividend, div_q;
    logic [pntp_pkg::TICK_W-1:0]   div_divisor;
    logic                          mul_start, mul_done;
    logic [pntp_pkg::COUNT_W-1:0]  mul_count;
    logic [pntp_pkg::NS_W-1:0]     mul_p;

    logic [pntp_pkg::CODE_W-1:0]   code_sel;
    logic [pntp_pkg::PCLK_W-1:0]   freq_sh;
    logic [pntp_pkg::TICK_W-1:0]   freq_div;
    logic [pntp_pkg::TICK_W-1:0]   tick_fix;
    logic                          ch_ok, ch_ok_in;
    logic [CH_IDX_W-1:0]           ch_idx, ch_idx_in;
    logic [pntp_pkg::COUNT_W-1:0]  cmp_sel;
    logic                          m_free;

    pntp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    pntp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (tick_reg),
        .mplier  (mul_count),
        .done    (mul_done),
        .product (mul_p)
    );

    always_comb begin
        freq_sh  = pclk_reg >> code_sel;
        freq_div = {{(pntp_pkg::TICK_W - pntp_pkg::PCLK_W){1'b0}},
                    (freq_sh == '0) ? pntp_pkg::PCLK_W'(1) : freq_sh};
        tick_fix = (div_q == '0) ? pntp_pkg::TICK_W'(1) : div_q[pntp_pkg::TICK_W-1:0];
        ch_ok     = {1'b0, ch_reg} < NCH;
        ch_ok_in  = {1'b0, s_channel} < NCH;
        ch_idx    = ch_reg[CH_IDX_W-1:0];
        ch_idx_in = s_channel[CH_IDX_W-1:0];
        cmp_sel   = ch_ok ? compare_reg[ch_idx] : '0;
        m_free    = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        ch_next           = ch_reg;
        period_next       = period_reg;
        pulse_next        = pulse_reg;
        tick_next         = tick_reg;
        pcount_next       = pcount_reg;
        cnt_next          = cnt_reg;
        k_next            = k_reg;
        code_new_next     = code_new_reg;
        status_next       = status_reg;
        pout_next         = pout_reg;
        wout_next         = wout_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_pout_next       = m_pout_reg;
        m_wout_next       = m_wout_reg;
        pclk_next         = cfg_wr_en ? cfg_wr_data : pclk_reg;
        div_code_next     = div_code_reg;
        period_count_next = period_count_reg;
        compare_next      = compare_reg;
        enable_next       = enable_reg;
        div_start         = 1'b0;
        div_dividend      = period_reg;
        div_divisor       = tick_reg;
        mul_start         = 1'b0;
        mul_count         = period_count_reg;
        code_sel          = div_code_reg;

        unique case (state_reg)
            pntp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mode_next   = s_mode;
                    ch_next     = s_channel;
                    period_next = s_period_ns;
                    pulse_next  = s_pulse_ns;
                    status_next = 1'b0;
                    pout_next   = '0;
                    wout_next   = '0;
                    unique case (s_mode)
                        pntp_pkg::MODE_SET, pntp_pkg::MODE_GET: begin
                            state_next = pntp_pkg::ST_TICK;
                        end
                        pntp_pkg::MODE_ENABLE: begin
                            if (ch_ok_in) begin
                                enable_next = enable_reg | (NUM_CHANNELS'(1) << ch_idx_in);
                            end
                            state_next = pntp_pkg::ST_DONE;
                        end
                        default: begin
                            if (ch_ok_in) begin
                                enable_next = enable_reg & ~(NUM_CHANNELS'(1) << ch_idx_in);
                            end
                            state_next = pntp_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            pntp_pkg::ST_TICK: begin
                code_sel     = div_code_reg;
                div_dividend = pntp_pkg::NS_PER_S;
                div_divisor  = freq_div;
                div_start    = launch_reg;
                if (div_done) begin
                    tick_next  = tick_fix;
                    state_next = (mode_reg == pntp_pkg::MODE_GET) ? pntp_pkg::ST_MUL_P
                                                                  : pntp_pkg::ST_PDIV;
                end
            end
            pntp_pkg::ST_PDIV: begin
                div_start = launch_reg;
                if (div_done) begin
                    if ({2'b00, tick_reg} >= period_reg || div_q > pntp_pkg::COUNT_LIMIT) begin
                        state_next = pntp_pkg::ST_TICK0;
                    end else begin
                        pcount_next   = div_q[pntp_pkg::COUNT_W-1:0];
                        code_new_next = div_code_reg;
                        state_next    = pntp_pkg::ST_WDIV;
                    end
                end
            end
            pntp_pkg::ST_TICK0: begin
                code_sel     = '0;
                div_dividend = pntp_pkg::NS_PER_S;
                div_divisor  = freq_div;
                div_start    = launch_reg;
                if (div_done) begin
                    tick_next  = tick_fix;
                    state_next = pntp_pkg::ST_CNT0;
                end
            end
            pntp_pkg::ST_CNT0: begin
                div_start = launch_reg;
                if (div_done) begin
                    cnt_next   = div_q;
                    k_next     = '0;
                    state_next = pntp_pkg::ST_SEARCH;
                end
            end
            pntp_pkg::ST_SEARCH: begin
                priority if (cnt_reg < pntp_pkg::COUNT_LIMIT) begin
                    code_new_next = k_reg;
                    state_next    = pntp_pkg::ST_TICKK;
                end else if (k_reg == MAX_CODE) begin
                    status_next = 1'b1;
                    state_next  = pntp_pkg::ST_DONE;
                end else begin
                    cnt_next = {1'b0, cnt_reg[pntp_pkg::NS_W-1:1]};
                    k_next   = k_reg + 1'b1;
                end
            end
            pntp_pkg::ST_TICKK: begin
                code_sel     = code_new_reg;
                div_dividend = pntp_pkg::NS_PER_S;
                div_divisor  = freq_div;
                div_start    = launch_reg;
                if (div_done) begin
                    tick_next  = tick_fix;
                    state_next = pntp_pkg::ST_PDIV2;
                end
            end
            pntp_pkg::ST_PDIV2: begin
                div_start = launch_reg;
                if (div_done) begin
                    pcount_next = div_q[pntp_pkg::COUNT_W-1:0];
                    state_next  = pntp_pkg::ST_WDIV;
                end
            end
            pntp_pkg::ST_WDIV: begin
                div_dividend = pulse_reg;
                div_start    = launch_reg;
                if (div_done) begin
                    div_code_next     = code_new_reg;
                    period_count_next = pcount_reg;
                    if (ch_ok) begin
                        compare_next[ch_idx] = div_q[pntp_pkg::COUNT_W-1:0];
                    end
                    state_next = pntp_pkg::ST_DONE;
                end
            end
            pntp_pkg::ST_MUL_P: begin
                mul_count = period_count_reg;
                mul_start = launch_reg;
                if (mul_done) begin
                    pout_next  = mul_p;
                    state_next = pntp_pkg::ST_MUL_W;
                end
            end
            pntp_pkg::ST_MUL_W: begin
                mul_count = cmp_sel;
                mul_start = launch_reg;
                if (mul_done) begin
                    wout_next  = mul_p;
                    state_next = pntp_pkg::ST_DONE;
                end
            end
            pntp_pkg::ST_DONE: begin
                if (m_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_pout_next   = pout_reg;
                    m_wout_next   = wout_reg;
                    state_next    = pntp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pntp_pkg::ST_IDLE;
            end
        endcase

        launch_next = state_next != state_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pntp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            launch_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
            pclk_reg         <= pntp_pkg::PCLK_RESET;
            div_code_reg     <= '0;
            period_count_reg <= '1;
            enable_reg       <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                compare_reg[i] <= '1;
            end
        end else begin
            launch_reg       <= launch_next;
            m_valid_reg      <= m_valid_next;
            pclk_reg         <= pclk_next;
            div_code_reg     <= div_code_next;
            period_count_reg <= period_count_next;
            enable_reg       <= enable_next;
            compare_reg      <= compare_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        ch_reg       <= ch_next;
        period_reg   <= period_next;
        pulse_reg    <= pulse_next;
        tick_reg     <= tick_next;
        pcount_reg   <= pcount_next;
        cnt_reg      <= cnt_next;
        k_reg        <= k_next;
        code_new_reg <= code_new_next;
        status_reg   <= status_next;
        pout_reg     <= pout_next;
        wout_reg     <= wout_next;
        m_status_reg <= m_status_next;
        m_pout_reg   <= m_pout_next;
        m_wout_reg   <= m_wout_next;
    end

    assign s_ready         = state_reg == pntp_pkg::ST_IDLE;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_period_ns_out = m_pout_reg;
    assign m_pulse_ns_out  = m_wout_reg;

endmodule

// File: rtl/pntp_checker.sv
// Port-level assertions for the PWM nanosecond-to-prescale block, bound to the top level.
module pntp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_status,
    input logic [pntp_pkg::NS_W-1:0]    m_period_ns_out,
    input logic [pntp_pkg::NS_W-1:0]    m_pulse_ns_out
);

    // Stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_period_ns_out) && $stable(m_pulse_ns_out))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

    // One request in flight.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_period_ns_out == '0 && m_pulse_ns_out == '0)
        else $error("error result carries data");

endmodule

bind pwm_ns_to_timer_prescale pntp_checker u_pntp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_period_ns_out (m_period_ns_out),
    .m_pulse_ns_out  (m_pulse_ns_out)
);

// File: tb/sv/tb_pwm_ns_to_timer_prescale.sv
// Testbench for pwm_ns_to_timer_prescale: random and directed requests checked against a local predictor.
`timescale 1ns / 1ps

module tb_pwm_ns_to_timer_prescale;

    localparam int NUM_CH   = 8;
    localparam int MAX_CODE = 10;
    localparam int RAND_PER_PHASE = 135;

    typedef struct packed {
        logic [pntp_pkg::MODE_W-1:0] mode;
        logic [pntp_pkg::CH_W-1:0]   channel;
        logic [pntp_pkg::NS_W-1:0]   period_ns;
        logic [pntp_pkg::NS_W-1:0]   pulse_ns;
    } pwm_req_t;

    typedef struct packed {
        logic                      status;
        logic [pntp_pkg::NS_W-1:0] period_ns;
        logic [pntp_pkg::NS_W-1:0] pulse_ns;
    } pwm_reply_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [pntp_pkg::PCLK_W-1:0] cfg_wr_data = pntp_pkg::PCLK_RESET;
    logic s_valid = 1'b0;
    logic s_ready;
    pwm_req_t drv_req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_status;
    logic [pntp_pkg::NS_W-1:0] m_period_ns_out;
    logic [pntp_pkg::NS_W-1:0] m_pulse_ns_out;

    pwm_req_t   req_q[$];
    pwm_reply_t reply_q[$];
    int errors = 0;
    bit calm = 1'b0;

    // predictor state
    logic [pntp_pkg::PCLK_W-1:0]  cur_pclk = pntp_pkg::PCLK_RESET;
    logic [pntp_pkg::CODE_W-1:0]  cur_code = '0;
    logic [pntp_pkg::COUNT_W-1:0] cur_period_cnt = '1;
    logic [pntp_pkg::COUNT_W-1:0] cur_cmp_cnt [NUM_CH];
    logic [NUM_CH-1:0]            cur_enable = '0;

    initial foreach (cur_cmp_cnt[i]) cur_cmp_cnt[i] = '1;

    pwm_ns_to_timer_prescale #(
        .NUM_CHANNELS(NUM_CH),
        .MAX_DIV_CODE(MAX_CODE)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(drv_req.mode),
        .s_channel(drv_req.channel),
        .s_period_ns(drv_req.period_ns),
        .s_pulse_ns(drv_req.pulse_ns),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_period_ns_out(m_period_ns_out),
        .m_pulse_ns_out(m_pulse_ns_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [63:0] tick_ns(logic [pntp_pkg::CODE_W-1:0] code);
        logic [63:0] freq;
        logic [63:0] t;
        freq = {36'd0, cur_pclk} >> code;
        if (freq == 0)
            freq = 1;
        t = 64'd1000000000 / freq;
        if (t == 0)
            t = 1;
        return t;
    endfunction

    function automatic pwm_reply_t predict_access(pwm_req_t a);
        pwm_reply_t r;
        logic [63:0] tick;
        logic [63:0] cnt;
        logic [63:0] prod;
        logic [pntp_pkg::CODE_W-1:0] code;
        int k;
        bit fail;
        r = '0;
        fail = 1'b0;
        case (a.mode)
            pntp_pkg::MODE_SET: begin
                tick = tick_ns(cur_code);
                cnt = a.period_ns / tick;
                code = cur_code;
                if (a.period_ns <= tick || cnt > pntp_pkg::COUNT_LIMIT) begin
                    cnt = a.period_ns / tick_ns('0);
                    for (k = 0; k <= MAX_CODE; k++) begin
                        if (cnt < pntp_pkg::COUNT_LIMIT)
                            break;
                        cnt = cnt >> 1;
                    end
                    if (k > MAX_CODE) begin
                        fail = 1'b1;
                    end else begin
                        code = pntp_pkg::CODE_W'(k);
                        tick = tick_ns(code);
                    end
                end
                if (fail) begin
                    r.status = 1'b1;
                end else begin
                    cur_code = code;
                    cnt = a.period_ns / tick;
                    cur_period_cnt = cnt[pntp_pkg::COUNT_W-1:0];
                    cnt = a.pulse_ns / tick;
                    if (a.channel < NUM_CH)
                        cur_cmp_cnt[a.channel] = cnt[pntp_pkg::COUNT_W-1:0];
                end
            end
            pntp_pkg::MODE_GET: begin
                tick = tick_ns(cur_code);
                prod = tick * cur_period_cnt;
                r.period_ns = prod[pntp_pkg::NS_W-1:0];
                if (a.channel < NUM_CH) begin
                    prod = tick * cur_cmp_cnt[a.channel];
                    r.pulse_ns = prod[pntp_pkg::NS_W-1:0];
                end
            end
            pntp_pkg::MODE_ENABLE: begin
                if (a.channel < NUM_CH)
                    cur_enable[a.channel] = 1'b1;
            end
            default: begin
                if (a.channel < NUM_CH)
                    cur_enable[a.channel] = 1'b0;
            end
        endcase
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                reply_q.push_back(predict_access(drv_req));
            if (!s_valid || s_ready) begin
                if (req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
                    s_valid <= 1'b1;
                    drv_req <= req_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [pntp_pkg::NS_W-1:0] exp_v,
                               logic [pntp_pkg::NS_W-1:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // monitor
    always @(posedge aclk) begin
        pwm_reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected reply: expected none, actual %b %h %h", $time,
                             m_status, m_period_ns_out, m_pulse_ns_out);
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", pntp_pkg::NS_W'(want.status),
                                pntp_pkg::NS_W'(m_status));
                    check_field("period_ns_out", want.period_ns, m_period_ns_out);
                    check_field("pulse_ns_out", want.pulse_ns, m_pulse_ns_out);
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    task automatic add_req(logic [pntp_pkg::MODE_W-1:0] mode, logic [pntp_pkg::CH_W-1:0] ch,
                           logic [pntp_pkg::NS_W-1:0] per, logic [pntp_pkg::NS_W-1:0] pul);
        pwm_req_t r;
        r.mode = mode;
        r.channel = ch;
        r.period_ns = per;
        r.pulse_ns = pul;
        req_q.push_back(r);
    endtask

    function automatic logic [pntp_pkg::NS_W-1:0] rand_ns();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return $urandom_range(0, 2000);
            default: return $urandom_range(1000, 700000000);
        endcase
    endfunction

    task automatic add_random_req();
        logic [pntp_pkg::MODE_W-1:0] mode;
        logic [pntp_pkg::NS_W-1:0] per;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            mode = pntp_pkg::MODE_SET;
        else if (pick < 80)
            mode = pntp_pkg::MODE_GET;
        else if (pick < 90)
            mode = pntp_pkg::MODE_ENABLE;
        else
            mode = pntp_pkg::MODE_DISABLE;
        per = rand_ns();
        // pulses mostly within the period
        add_req(mode, pntp_pkg::CH_W'($urandom_range(0, 7)), per,
                ($urandom_range(0, 3) == 0) ? rand_ns()
                                            : pntp_pkg::NS_W'($urandom_range(0, per)));
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (req_q.size() != 0 || s_valid || reply_q.size() != 0);
    endtask

    task automatic write_pclk(logic [pntp_pkg::PCLK_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cur_pclk = v;
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [pntp_pkg::PCLK_W-1:0] pclk_list [8];
        pclk_list = '{28'd250000000, 28'd1000000, 28'd0, 28'd100000000,
                      28'd0, 28'd1000000, 28'd0, 28'd250000000};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        add_req(pntp_pkg::MODE_GET,     3'd0, 32'd0,         32'd0);
        add_req(pntp_pkg::MODE_SET,     3'd0, 32'd0,         32'd0);
        add_req(pntp_pkg::MODE_GET,     3'd0, 32'hFFFFFFFF,  32'hFFFFFFFF);
        add_req(pntp_pkg::MODE_SET,     3'd1, 32'd10,        32'd5);
        add_req(pntp_pkg::MODE_SET,     3'd2, 32'd1000,      32'd500);
        add_req(pntp_pkg::MODE_GET,     3'd2, 32'd0,         32'd0);
        add_req(pntp_pkg::MODE_SET,     3'd7, 32'hFFFFFFFF,  32'hFFFFFFFF);
        add_req(pntp_pkg::MODE_GET,     3'd7, 32'd0,         32'd0);
        add_req(pntp_pkg::MODE_SET,     3'd3, 32'd10000000,  32'hFFFFFFFF);
        add_req(pntp_pkg::MODE_GET,     3'd3, 32'd0,         32'd0);
        add_req(pntp_pkg::MODE_SET,     3'd5, 32'd5000,      32'd2500);
        add_req(pntp_pkg::MODE_SET,     3'd6, 32'd100,       32'd50);
        add_req(pntp_pkg::MODE_SET,     3'd0, 32'd655350,    32'd655350);
        add_req(pntp_pkg::MODE_GET,     3'd0, 32'd0,         32'd0);
        add_req(pntp_pkg::MODE_SET,     3'd0, 32'd655360,    32'd1);
        add_req(pntp_pkg::MODE_GET,     3'd0, 32'd0,         32'd0);
        add_req(pntp_pkg::MODE_SET,     3'd1, 32'd671078399, 32'd671078399);
        add_req(pntp_pkg::MODE_GET,     3'd1, 32'd0,         32'd0);
        add_req(pntp_pkg::MODE_SET,     3'd1, 32'd671088640, 32'd0);
        add_req(pntp_pkg::MODE_GET,     3'd1, 32'd0,         32'd0);
        add_req(pntp_pkg::MODE_ENABLE,  3'd0, 32'hFFFFFFFF,  32'hFFFFFFFF);
        add_req(pntp_pkg::MODE_ENABLE,  3'd7, 32'd0,         32'd0);
        add_req(pntp_pkg::MODE_DISABLE, 3'd7, 32'hFFFFFFFF,  32'd0);
        add_req(pntp_pkg::MODE_DISABLE, 3'd0, 32'd0,         32'hFFFFFFFF);
        add_req(pntp_pkg::MODE_GET,     3'd5, 32'hFFFFFFFF,  32'hFFFFFFFF);
        wait_drained();

        foreach (pclk_list[p]) begin
            write_pclk(pclk_list[p] != 0
                       ? pclk_list[p]
                       : pntp_pkg::PCLK_W'($urandom_range(1000000, 250000000)));
            calm = (p == 3);
            repeat (RAND_PER_PHASE) add_random_req();
            wait_drained();
        end
        calm = 1'b0;

        repeat (250) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #25_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
